### design/slre_pkg.sv
// Shared types and constants for the stippled line raster engine.
// Command and result word layouts, request codes, raster op codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slre_pkg;

  typedef enum logic [1:0] {
    REQ_HLINE = 2'd0,
    REQ_VLINE = 2'd1,
    REQ_BAND  = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  // raster op codes; the unused code acts as xor
  localparam logic [1:0] ROP_XOR = 2'd0;
  localparam logic [1:0] ROP_SET = 2'd1;
  localparam logic [1:0] ROP_CLR = 2'd2;

  localparam logic [7:0] NIB_LO   = 8'h0F;
  localparam logic [7:0] NIB_HI   = 8'hF0;
  localparam logic [7:0] PAT_TOP  = 8'h80;
  localparam logic [7:0] BYTE_ALL = 8'hFF;

  typedef struct packed {
    req_t               req_type;
    logic [7:0]         x;
    logic signed [8:0]  y;
    logic signed [8:0]  length;
    logic [7:0]         pattern;
    logic [3:0]         grey;
    logic [1:0]         raster_op;
    logic               blank_only;
    logic [12:0]        read_addr;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       status;
  } result_t;

endpackage

`default_nettype wire

### design/slre_ram.sv
// Frame store: single write port, single read port, registered read data.
// Used by slre_ctrl through the top level; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module slre_ram #(
  parameter int DEPTH = 6784,
  parameter int AW    = 13
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/slre_ctrl.sv
// Command sequencer: clips a command, walks its bytes, read-modify-writes
// the frame store with forwarding between back-to-back same-byte pixels.
// Depends on slre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slre_ctrl #(
  parameter int W           = 212,
  parameter int H           = 64,
  parameter int DOT         = 85,
  parameter int STORE_BYTES = 6784,
  parameter int AW          = 13
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire slre_pkg::cmd_t    in_cmd,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output slre_pkg::result_t      res,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [7:0]             mem_wdata,
  output logic [AW-1:0]          mem_raddr,
  input  wire logic [7:0]        mem_rdata
);

  localparam int BAND_BYTES = 4 * W;
  localparam int HALF       = (H + 1) / 2;
  localparam int CNT_MAX    = (BAND_BYTES > H) ? BAND_BYTES : H;
  localparam int CNT_W      = $clog2(CNT_MAX + 1);
  localparam int SW         = 11;
  localparam logic signed [SW-1:0] W_S    = SW'(W);
  localparam logic signed [SW-1:0] H_S    = SW'(H);
  localparam logic signed [SW-1:0] HALF_S = SW'(HALF);
  localparam logic [7:0]           DOT_P  = 8'(DOT);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PREP, S_CLIP, S_ADDR, S_RUN, S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  slre_pkg::cmd_t        cmd_r, cmd_nxt;
  logic signed [SW-1:0]  wy_r, wy_nxt, wl_r, wl_nxt;
  logic                  rej_r, rej_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [7:0]            pat_r, pat_nxt;
  logic                  odd_r, odd_nxt;
  logic [7:0]            rd_r, rd_nxt;
  logic                  b_valid_r, b_valid_nxt;
  logic [AW-1:0]         b_addr_r, b_addr_nxt;
  logic [7:0]            b_mask_r, b_mask_nxt;
  logic                  b_draw_r, b_draw_nxt;
  logic                  w_valid_r, w_valid_nxt;
  logic [AW-1:0]         w_addr_r, w_addr_nxt;
  logic [7:0]            w_data_r, w_data_nxt;

  logic signed [SW-1:0]  y_s, len_s, x_s, room, lim;
  logic [31:0]           rem;
  logic [3:0]            nib;
  logic [7:0]            cur, msk, newb;
  logic [1:0]            eff_op;
  logic                  is_band;

  // stage B: merge forwarded byte, apply mask
  always_comb begin
    is_band = (cmd_r.req_type == slre_pkg::REQ_BAND);
    cur = (w_valid_r && (w_addr_r == b_addr_r)) ? w_data_r : mem_rdata;
    msk = b_mask_r;
    if (cmd_r.blank_only && !is_band) begin
      if ((cur & slre_pkg::NIB_LO) != 8'h00) msk = msk & slre_pkg::NIB_HI;
      if ((cur & slre_pkg::NIB_HI) != 8'h00) msk = msk & slre_pkg::NIB_LO;
    end
    eff_op = is_band ? slre_pkg::ROP_XOR : cmd_r.raster_op;
    priority case (eff_op)
      slre_pkg::ROP_SET: newb = cur | msk;
      slre_pkg::ROP_CLR: newb = cur & ~msk;
      default:           newb = cur ^ msk;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    wy_nxt      = wy_r;
    wl_nxt      = wl_r;
    rej_nxt     = rej_r;
    addr_nxt    = addr_r;
    cnt_nxt     = cnt_r;
    pat_nxt     = pat_r;
    odd_nxt     = odd_r;
    rd_nxt      = rd_r;
    b_valid_nxt = 1'b0;
    b_addr_nxt  = b_addr_r;
    b_mask_nxt  = b_mask_r;
    b_draw_nxt  = b_draw_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    mem_raddr   = addr_r;
    mem_we      = b_valid_r && b_draw_r;
    mem_waddr   = b_addr_r;
    mem_wdata   = newb;
    y_s   = SW'($signed(cmd_r.y));
    len_s = SW'($signed(cmd_r.length));
    x_s   = SW'({1'b0, cmd_r.x});
    room  = W_S - x_s;
    lim   = wl_r;
    rem   = 32'(STORE_BYTES) - 32'(addr_r);
    nib   = 4'hF - cmd_r.grey;

    w_valid_nxt = b_valid_r && b_draw_r;
    w_addr_nxt  = b_addr_r;
    w_data_nxt  = newb;
    if (b_valid_r && (cmd_r.req_type == slre_pkg::REQ_READ)) begin
      rd_nxt = mem_rdata;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = 8'h00;
        addr_nxt  = addr_r + 1'b1;
        if (32'(addr_r) == 32'(STORE_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        rd_nxt = 8'h00;
        wy_nxt = y_s;
        wl_nxt = '0;
        unique case (cmd_r.req_type)
          slre_pkg::REQ_HLINE: begin
            rej_nxt = y_s[SW-1] || (y_s >= H_S) || (x_s >= W_S);
            if (len_s > 0) begin
              wl_nxt = (len_s > room) ? room : len_s;
            end
          end
          slre_pkg::REQ_VLINE: begin
            rej_nxt = (x_s >= W_S) || (y_s >= H_S);
            if (len_s[SW-1]) begin
              wy_nxt = y_s + len_s;
              wl_nxt = -len_s;
            end else begin
              wl_nxt = len_s;
            end
          end
          slre_pkg::REQ_BAND: begin
            rej_nxt = y_s[SW-1] || ((y_s <<< 2) >= HALF_S);
          end
          default: begin
            rej_nxt = 32'(cmd_r.read_addr) >= 32'(STORE_BYTES);
          end
        endcase
        state_nxt = S_CLIP;
      end
      S_CLIP: begin
        if (cmd_r.req_type == slre_pkg::REQ_VLINE && wy_r[SW-1]) begin
          wl_nxt = wl_r + wy_r;
          wy_nxt = '0;
        end
        // band start: y * 4 * width
        addr_nxt  = AW'(32'(wy_r[7:0]) * 32'(BAND_BYTES));
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        pat_nxt = cmd_r.pattern;
        odd_nxt = wy_r[0];
        cnt_nxt = '0;
        unique case (cmd_r.req_type)
          slre_pkg::REQ_HLINE: begin
            addr_nxt = AW'(32'(wy_r[7:1]) * 32'(W) + 32'(cmd_r.x));
            cnt_nxt  = CNT_W'(wl_r);
          end
          slre_pkg::REQ_VLINE: begin
            addr_nxt = AW'(32'(wy_r[7:1]) * 32'(W) + 32'(cmd_r.x));
            if (wy_r + wl_r > H_S) lim = H_S - wy_r;
            if (lim > 0) cnt_nxt = CNT_W'(lim);
            if (cmd_r.pattern == DOT_P && !wy_r[0]) pat_nxt = ~cmd_r.pattern;
          end
          slre_pkg::REQ_BAND: begin
            cnt_nxt = (rem < 32'(BAND_BYTES)) ? CNT_W'(rem) : CNT_W'(BAND_BYTES);
          end
          default: begin
            addr_nxt = AW'(cmd_r.read_addr);
            cnt_nxt  = CNT_W'(1);
          end
        endcase
        if (rej_r) cnt_nxt = '0;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (cnt_r != '0) begin
          b_valid_nxt = 1'b1;
          b_addr_nxt  = addr_r;
          cnt_nxt     = cnt_r - 1'b1;
          pat_nxt     = {pat_r[0], pat_r[7:1]};
          unique case (cmd_r.req_type)
            slre_pkg::REQ_BAND: begin
              b_mask_nxt = slre_pkg::BYTE_ALL;
              b_draw_nxt = 1'b1;
              addr_nxt   = addr_r + 1'b1;
            end
            slre_pkg::REQ_READ: begin
              b_mask_nxt = 8'h00;
              b_draw_nxt = 1'b0;
            end
            slre_pkg::REQ_VLINE: begin
              b_mask_nxt = odd_r ? {nib, 4'h0} : {4'h0, nib};
              b_draw_nxt = pat_r[0];
              // advance to the next byte row after an odd row
              addr_nxt   = odd_r ? AW'(32'(addr_r) + 32'(W)) : addr_r;
              odd_nxt    = ~odd_r;
            end
            default: begin
              b_mask_nxt = odd_r ? {nib, 4'h0} : {4'h0, nib};
              b_draw_nxt = pat_r[0];
              addr_nxt   = addr_r + 1'b1;
            end
          endcase
        end else if (!b_valid_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res.read_data = rd_r;
  assign res.status    = rej_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      addr_r    <= '0;
      cnt_r     <= '0;
      b_valid_r <= 1'b0;
      w_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      addr_r    <= addr_nxt;
      cnt_r     <= cnt_nxt;
      b_valid_r <= b_valid_nxt;
      w_valid_r <= w_valid_nxt;
    end
    cmd_r    <= cmd_nxt;
    wy_r     <= wy_nxt;
    wl_r     <= wl_nxt;
    rej_r    <= rej_nxt;
    pat_r    <= pat_nxt;
    odd_r    <= odd_nxt;
    rd_r     <= rd_nxt;
    b_addr_r <= b_addr_nxt;
    b_mask_r <= b_mask_nxt;
    b_draw_r <= b_draw_nxt;
    w_addr_r <= w_addr_nxt;
    w_data_r <= w_data_nxt;
  end

  a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(mem_waddr) < 32'(STORE_BYTES)))
    else $error("write address beyond frame store");

  a_result_drained: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !b_valid_r)
    else $error("result offered with a pixel still in flight");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("word accepted during clearing pass");

  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && cmd_r.req_type == slre_pkg::REQ_READ) |-> !mem_we)
    else $error("read command modified the store");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && cnt_r != '0) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("pixel counter skipped");

endmodule

`default_nettype wire

### design/stippled_line_raster_engine.sv
// Stippled line raster engine: 4-bit grey framebuffer with two rows a byte.
// Top level: stream ports, result register; uses slre_ctrl, slre_ram, slre_pkg.
//
// Usage:
//   in_*  carries one command word (hline, vline, invert band, read byte).
//   out_* returns one result word per command: read_data and status.
//   Each command walks the frame store through a single read port and a
//   write port that writes each byte in the cycle after its read, so the
//   next pixel is read while the previous one is written; a pixel pair that
//   shares a byte is forwarded from the previous write. Steps per command:
//     hline  : clipped length   (at most SCREEN_WIDTH)
//     vline  : clipped length   (at most SCREEN_HEIGHT)
//     band   : clipped band bytes (at most 4 * SCREEN_WIDTH)
//     read : one byte; rejected command or empty line : none
//   One command is in work at a time; the next one is accepted while the
//   previous result still waits in the output register.
//   After reset the store is swept to zero, one byte a cycle, all
//   SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 2) bytes (6784 by default), with
//   in_tready low. A stalled out_tready holds the result word; the block
//   finishes at most one further command and then waits.
`timescale 1ns / 1ps
`default_nettype none

module stippled_line_raster_engine #(
  parameter int SCREEN_WIDTH  = 212,
  parameter int SCREEN_HEIGHT = 64,
  parameter int DOT_PATTERN   = 85
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // req_type[1:0], x[9:2], y[18:10], length[27:19], pattern[35:28],
  // grey[39:36], raster_op[41:40], blank_only[42], read_addr[55:43]
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // read_data[7:0], status[8], zero[15:9]
  output logic [15:0]      out_tdata
);

  localparam int STORE_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 1) / 2);
  localparam int AW          = $clog2(STORE_BYTES);

  slre_pkg::cmd_t    cmd;
  slre_pkg::result_t res;
  slre_pkg::result_t out_data_r;
  logic              out_valid_r;
  logic              res_valid, res_ready;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  always_comb begin
    cmd.req_type   = slre_pkg::req_t'(in_tdata[1:0]);
    cmd.x          = in_tdata[9:2];
    cmd.y          = in_tdata[18:10];
    cmd.length     = in_tdata[27:19];
    cmd.pattern    = in_tdata[35:28];
    cmd.grey       = in_tdata[39:36];
    cmd.raster_op  = in_tdata[41:40];
    cmd.blank_only = in_tdata[42];
    cmd.read_addr  = in_tdata[55:43];
  end

  slre_ctrl #(
    .W           (SCREEN_WIDTH),
    .H           (SCREEN_HEIGHT),
    .DOT         (DOT_PATTERN),
    .STORE_BYTES (STORE_BYTES),
    .AW          (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  slre_ram #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // take a new result once the register is empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_data_r.status, out_data_r.read_data};

endmodule

`default_nettype wire
